### design/sof_length_tail_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
// Each expects clk and rst_n in scope at the point of use.
`ifndef SOF_LENGTH_TAIL_DEFRAMER_ASSERT_SVH
`define SOF_LENGTH_TAIL_DEFRAMER_ASSERT_SVH

// Checked only while out of reset.
`define SLTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SLTD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/sltd_pkg.sv
// Package for the SOF/length/tail deframer: widths, codes, types.
// No dependencies.
package sltd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 10;
    localparam int STATUS_W = 3;
    localparam int FULL_W   = 17;

    localparam logic [BYTE_W-1:0]   SOF_A          = 8'hAA;
    localparam logic [BYTE_W-1:0]   SOF_B          = 8'h55;
    localparam logic [OFFSET_W-1:0] LEN_HI_OFFSET  = 10'd14;
    localparam logic [OFFSET_W-1:0] HEADER_DONE    = 10'd16;
    localparam logic [FULL_W-1:0]   LEN_OVERHEAD   = 17'd20;
    localparam logic [OFFSET_W-1:0] MAX_LEN_RESET  = 10'd600;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SOF1    = 2'd1,
        MODE_SOF2    = 2'd2,
        MODE_COLLECT = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OUTSIDE  = 3'd0,
        ST_BYTE     = 3'd1,
        ST_GOOD     = 3'd2,
        ST_BADTAIL  = 3'd3,
        ST_TOOLONG  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [OFFSET_W-1:0] frame_offset;
        status_t             status;
    } result_t;

endpackage

### design/sltd_if.sv
// Valid/ready channel interfaces for the deframer's input and result items.
// Depends on sltd_pkg.
interface sltd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [sltd_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sltd_result_if;
    logic                          valid;
    logic                          ready;
    logic [sltd_pkg::BYTE_W-1:0]   out_byte;
    logic [sltd_pkg::OFFSET_W-1:0] frame_offset;
    logic [sltd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output out_byte, output frame_offset, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_offset, input status,
                    output ready);
endinterface

### design/sof_length_tail_deframer.sv
// Top level of the SOF/length/tail deframer: input register, parser, result register.
// Depends on sltd_pkg, sltd_if.sv, sltd_core and sof_length_tail_deframer_assert.svh.
//
//   channel      dir   handshake      payload
//   byte_ch      in    valid/ready    data_byte[7:0]
//   result_ch    out   valid/ready    out_byte[7:0], frame_offset[9:0], status[2:0]
//   cfg_wr_*     in    write enable   max_frame_len[9:0]
//
// One item per cycle sustained while the result side is ready; an accepted item
// passes the input register, then the result register, before it is offered.
// The parser state advances when the input register hands its item to the
// result register; all step logic sits between those two registers.
// A stalled result still lets one more item into the input register.
// rst_n clears state asynchronously; max_frame_len resets to 600.
`include "sof_length_tail_deframer_assert.svh"

module sof_length_tail_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    sltd_byte_if.sink                     byte_ch,
    sltd_result_if.source                 result_ch,
    input  logic                          cfg_wr_en,
    input  logic [sltd_pkg::OFFSET_W-1:0] cfg_wr_data
);

    // configuration
    logic [sltd_pkg::OFFSET_W-1:0] max_len_reg;

    // input stage
    logic                          in_valid_reg;
    logic [sltd_pkg::BYTE_W-1:0]   in_byte_reg;

    // result stage
    logic                          out_valid_reg;
    sltd_pkg::result_t             out_res_reg;

    sltd_pkg::result_t             step_res;
    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    // result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || result_ch.ready;
    assign advance  = in_valid_reg && out_free;
    // input register can load when empty or emptying into the result register
    assign byte_ch.ready = !in_valid_reg || out_free;
    assign in_take       = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= sltd_pkg::MAX_LEN_RESET;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ch.ready)
                in_valid_reg <= byte_ch.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= byte_ch.data_byte;
        if (advance)
            out_res_reg <= step_res;
    end

    sltd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .max_frame_len (max_len_reg),
        .res           (step_res)
    );

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.out_byte     = out_res_reg.out_byte;
    assign result_ch.frame_offset = out_res_reg.frame_offset;
    assign result_ch.status       = out_res_reg.status;

    `SLTD_ASSERT(a_hold_input, (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)), "input item dropped while result stalled")
    `SLTD_ASSERT(a_outside_zero_offset, (out_valid_reg && out_res_reg.status == sltd_pkg::ST_OUTSIDE) |-> (out_res_reg.frame_offset == '0), "outside byte carries an offset")
    `SLTD_ASSERT(a_advance_fills, advance |=> out_valid_reg, "advanced item missing from result register")

endmodule

### design/sltd_core.sv
// Parser state and one-byte step logic of the deframer.
// Depends on sltd_pkg and sof_length_tail_deframer_assert.svh.
`include "sof_length_tail_deframer_assert.svh"

module sltd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [sltd_pkg::BYTE_W-1:0]   data_byte,
    input  logic [sltd_pkg::OFFSET_W-1:0] max_frame_len,
    output sltd_pkg::result_t             res
);

    sltd_pkg::mode_t               mode_reg, mode_next;
    logic [sltd_pkg::OFFSET_W-1:0] count_reg, count_next;
    logic [sltd_pkg::OFFSET_W-1:0] exp_reg, exp_next;
    logic [sltd_pkg::BYTE_W-1:0]   len_hi_reg, len_hi_next;
    logic [sltd_pkg::BYTE_W-1:0]   prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sltd_pkg::MODE_IDLE;
            count_reg  <= '0;
            exp_reg    <= '0;
            len_hi_reg <= '0;
            prev_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            exp_reg    <= exp_next;
            len_hi_reg <= len_hi_next;
            prev_reg   <= data_byte;
        end
    end

    always_comb
    begin
        logic [sltd_pkg::OFFSET_W-1:0] cnt_inc;
        logic [sltd_pkg::BYTE_W-1:0]   hi;
        logic [sltd_pkg::FULL_W-1:0]   full;
        logic [sltd_pkg::OFFSET_W-1:0] exp_eff;
        logic                          collecting;

        mode_next        = mode_reg;
        count_next       = count_reg;
        exp_next         = exp_reg;
        len_hi_next      = len_hi_reg;
        res.out_byte     = data_byte;
        res.frame_offset = '0;
        res.status       = sltd_pkg::ST_OUTSIDE;

        cnt_inc    = count_reg + 10'd1;
        hi         = (count_reg == sltd_pkg::LEN_HI_OFFSET) ? data_byte : len_hi_reg;
        full       = {1'b0, hi, data_byte} + sltd_pkg::LEN_OVERHEAD;
        exp_eff    = exp_reg;
        collecting = (mode_reg == sltd_pkg::MODE_COLLECT);

        case (mode_reg)
            sltd_pkg::MODE_IDLE:
            begin
                if (data_byte == sltd_pkg::SOF_A)
                begin
                    mode_next  = sltd_pkg::MODE_SOF1;
                    count_next = 10'd1;
                    res.status = sltd_pkg::ST_BYTE;
                end
            end
            sltd_pkg::MODE_SOF1:
            begin
                if (data_byte == sltd_pkg::SOF_B)
                begin
                    mode_next        = sltd_pkg::MODE_SOF2;
                    count_next       = 10'd2;
                    res.frame_offset = 10'd1;
                    res.status       = sltd_pkg::ST_BYTE;
                end
                else if (data_byte == sltd_pkg::SOF_A)
                begin
                    count_next = 10'd1;
                    res.status = sltd_pkg::ST_BYTE;
                end
                else
                begin
                    mode_next  = sltd_pkg::MODE_IDLE;
                    count_next = '0;
                    exp_next   = '0;
                end
            end
            default:
            begin
                res.frame_offset = count_reg;
                if (count_reg >= max_frame_len)
                begin
                    res.status = sltd_pkg::ST_OVERFLOW;
                    mode_next  = sltd_pkg::MODE_IDLE;
                    count_next = '0;
                    exp_next   = '0;
                end
                else
                begin
                    res.status  = sltd_pkg::ST_BYTE;
                    len_hi_next = hi;
                    count_next  = cnt_inc;
                    if (cnt_inc == sltd_pkg::HEADER_DONE)
                    begin
                        if (full > {7'd0, max_frame_len})
                        begin
                            res.status = sltd_pkg::ST_TOOLONG;
                            mode_next  = sltd_pkg::MODE_IDLE;
                            count_next = '0;
                            exp_next   = '0;
                        end
                        else
                        begin
                            exp_eff    = full[sltd_pkg::OFFSET_W-1:0];
                            exp_next   = exp_eff;
                            mode_next  = sltd_pkg::MODE_COLLECT;
                            collecting = 1'b1;
                        end
                    end
                    // tail check once the count reaches the expected length
                    if (res.status == sltd_pkg::ST_BYTE && collecting && cnt_inc >= exp_eff)
                    begin
                        res.status = (prev_reg == sltd_pkg::SOF_B &&
                                      data_byte == sltd_pkg::SOF_A) ?
                                     sltd_pkg::ST_GOOD : sltd_pkg::ST_BADTAIL;
                        mode_next  = sltd_pkg::MODE_IDLE;
                        count_next = '0;
                        exp_next   = '0;
                    end
                end
            end
        endcase
    end

    `SLTD_ASSERT_ALWAYS(a_idle_count_zero, (mode_reg == sltd_pkg::MODE_IDLE) |-> (count_reg == '0), "idle parser holds a nonzero count")
    `SLTD_ASSERT(a_end_clears, (advance && res.status != sltd_pkg::ST_BYTE) |=> (mode_reg == sltd_pkg::MODE_IDLE && count_reg == '0), "frame end or miss did not return to idle")
    `SLTD_ASSERT(a_collect_len, (mode_reg == sltd_pkg::MODE_COLLECT) |-> (exp_reg >= 10'd20 && count_reg >= sltd_pkg::HEADER_DONE), "collecting with an impossible expected length")

endmodule

### tb/sltd_frame_checker.sv
// Scoreboard for the SOF/length/tail deframer: predicts the echo of each accepted byte.
// Depends on sltd_pkg and the channel interfaces in sltd_if.sv.
`timescale 1ns / 1ps

module sltd_frame_checker
    import sltd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sltd_byte_if                byte_ch,
    sltd_result_if              result_ch,
    input  logic                cfg_wr_en,
    input  logic [OFFSET_W-1:0] cfg_wr_data,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int MAX_REPORTS = 200;

    // Shadow copy of the parser state and its one register.
    mode_t               mode;
    logic [OFFSET_W-1:0] frame_count;
    logic [OFFSET_W-1:0] frame_len;
    logic [OFFSET_W-1:0] max_len;
    logic [BYTE_W-1:0]   len_hi;
    logic [BYTE_W-1:0]   last_byte;

    result_t echo_q[$];
    int      errors;

    assign fail_count = errors;

    function automatic void drop_frame();
        mode        = MODE_IDLE;
        frame_count = '0;
        frame_len   = '0;
    endfunction

    // Next echo for one received byte; advances the shadow parser.
    function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
        result_t     r;
        logic [16:0] whole_len;
        r.out_byte     = b;
        r.frame_offset = '0;
        r.status       = ST_OUTSIDE;
        case (mode)
            MODE_IDLE:
            begin
                if (b == SOF_A)
                begin
                    mode        = MODE_SOF1;
                    frame_count = 10'd1;
                    r.status    = ST_BYTE;
                end
            end
            MODE_SOF1:
            begin
                if (b == SOF_B)
                begin
                    mode           = MODE_SOF2;
                    frame_count    = 10'd2;
                    r.frame_offset = 10'd1;
                    r.status       = ST_BYTE;
                end
                else if (b == SOF_A)
                begin
                    frame_count = 10'd1;
                    r.status    = ST_BYTE;
                end
                else
                begin
                    drop_frame();
                end
            end
            default:
            begin
                if (frame_count >= max_len)
                begin
                    r.frame_offset = frame_count;
                    r.status       = ST_OVERFLOW;
                    drop_frame();
                end
                else
                begin
                    r.frame_offset = frame_count;
                    r.status       = ST_BYTE;
                    if (frame_count == LEN_HI_OFFSET)
                        len_hi = b;
                    frame_count = frame_count + 10'd1;
                    if (frame_count == HEADER_DONE)
                    begin
                        // full-width sum, no wrap before the compare
                        whole_len = {1'b0, len_hi, b} + LEN_OVERHEAD;
                        if (whole_len > {7'd0, max_len})
                        begin
                            r.status = ST_TOOLONG;
                            drop_frame();
                        end
                        else
                        begin
                            frame_len = whole_len[OFFSET_W-1:0];
                            mode      = MODE_COLLECT;
                        end
                    end
                    if (mode == MODE_COLLECT && frame_count >= frame_len)
                    begin
                        r.status = (last_byte == SOF_B && b == SOF_A) ? ST_GOOD : ST_BADTAIL;
                        drop_frame();
                    end
                end
            end
        endcase
        last_byte = b;
        return r;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            mode        = MODE_IDLE;
            frame_count = '0;
            frame_len   = '0;
            max_len     = MAX_LEN_RESET;
            len_hi      = '0;
            last_byte   = '0;
            echo_q.delete();
            errors      = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                max_len = cfg_wr_data;
            if (byte_ch.valid && byte_ch.ready)
                echo_q.push_back(parse_byte(byte_ch.data_byte));
            if (result_ch.valid && result_ch.ready)
            begin
                if (echo_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item: expected none, actual byte %0d offset %0d status %0d",
                             $time, result_ch.out_byte, result_ch.frame_offset, result_ch.status);
                end
                else
                begin
                    want = echo_q.pop_front();
                    check_field("out_byte", want.out_byte, result_ch.out_byte);
                    check_field("frame_offset", want.frame_offset, result_ch.frame_offset);
                    check_field("status", want.status, result_ch.status);
                end
            end
            outstanding <= echo_q.size();
        end
    end

endmodule

### tb/sof_length_tail_deframer_tb.sv
// Top of the deframer testbench: clock, reset, byte stimulus, config writes, verdict.
// Depends on sltd_pkg, sltd_if.sv, sltd_frame_checker and the deframer RTL.
`timescale 1ns / 1ps

module sof_length_tail_deframer_tb;
    import sltd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;       // settling margin after the last result
    localparam int PHASE_ITEMS  = 125;

    // How the two tail bytes of a generated frame are formed.
    typedef enum int {
        TAIL_GOOD,
        TAIL_FIRST_BAD,
        TAIL_SECOND_BAD,
        TAIL_RANDOM
    } tail_kind_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en;
    logic [OFFSET_W-1:0] cfg_wr_data;
    int                  fail_count;
    int                  outstanding;
    int                  cycles = 0;

    // Stimulus bookkeeping.
    int unsigned         cur_max = MAX_LEN_RESET;
    int unsigned         items_sent = 0;
    bit                  quiet = 1'b0;     // set: neither side idles

    sltd_byte_if   byte_ch ();
    sltd_result_if result_ch ();

    sof_length_tail_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .result_ch  (result_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    sltd_frame_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .result_ch  (result_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side back-pressure: stalls about a quarter of the cycles outside quiet stretches.
    always @(posedge clk)
    begin
        result_ch.ready <= quiet || ($urandom_range(0, 99) >= 25);
    end

    // One byte item; random idle cycles before it unless in a quiet stretch.
    // Valid stays high after accept so back-to-back items need no re-raise.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!quiet && $urandom_range(0, 99) < 25)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // A frame of payload+20 bytes: start pair, 12 header bytes, length at 14/15,
    // payload+2 random bytes, then the tail. cut truncates it after that many bytes.
    task automatic send_frame(input int unsigned payload, input tail_kind_t tail,
                              input int unsigned cut);
        int unsigned     whole;
        int unsigned     n;
        logic [BYTE_W-1:0] b;
        whole = payload + 20;
        for (n = 0; n < whole && n < cut; n++)
        begin
            if (n == 0)
                b = SOF_A;
            else if (n == 1)
                b = SOF_B;
            else if (n == 14)
                b = payload[15:8];
            else if (n == 15)
                b = payload[7:0];
            else if (n == whole - 2 && tail != TAIL_RANDOM)
                b = (tail == TAIL_FIRST_BAD) ? (SOF_B ^ 8'($urandom_range(1, 255))) : SOF_B;
            else if (n == whole - 1 && tail != TAIL_RANDOM)
                b = (tail == TAIL_SECOND_BAD) ? (SOF_A ^ 8'($urandom_range(1, 255))) : SOF_A;
            else
                b = 8'($urandom);
            send_byte(b);
        end
    endtask

    // Mostly well-formed frames with random content; the rest is noise,
    // broken start pairs, oversize lengths, bad tails and cut-off frames.
    task automatic send_random_chunk();
        int unsigned r;
        int unsigned fit;
        int unsigned lim;
        int unsigned payload;
        r   = $urandom_range(0, 99);
        fit = cur_max - 20;
        lim = (fit < 40) ? fit : 40;
        if (r < 10)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom));
        end
        else if (r < 16)
        begin
            // start byte, maybe repeated, then anything
            send_byte(SOF_A);
            if ($urandom_range(0, 1))
                send_byte(SOF_A);
            send_byte(8'($urandom));
        end
        else if (r < 26)
        begin
            // length just over the limit, or anywhere above it; frame stops at offset 15
            payload = ($urandom_range(0, 3) == 0) ? fit + 1 : $urandom_range(fit + 1, 65535);
            send_frame(payload, TAIL_GOOD, 16);
        end
        else if (r < 36)
        begin
            send_frame($urandom_range(0, lim),
                       tail_kind_t'($urandom_range(TAIL_FIRST_BAD, TAIL_RANDOM)), 65535);
        end
        else if (r < 42)
        begin
            payload = $urandom_range(0, lim);
            send_frame(payload, TAIL_GOOD, $urandom_range(3, payload + 19));
        end
        else
        begin
            // exact-fit frames now and then, only while the limit keeps them short
            if (cur_max <= 128 && $urandom_range(0, 24) == 0)
                payload = fit;
            else
                payload = $urandom_range(0, lim);
            send_frame(payload, TAIL_GOOD, 65535);
        end
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Register write only with nothing in flight; parser may be mid-frame.
    task automatic set_max_len(input int unsigned len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[OFFSET_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_max = len;
    endtask

    initial
    begin
        int          p;
        int unsigned next_max;
        int unsigned target;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        result_ch.ready   = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset limit of 600: bytes outside a frame at both
        // extremes, a start pair broken by another byte, a repeated start byte,
        // then the shortest good frame (zero payload).
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SOF_A);
        send_byte(8'h13);
        send_byte(SOF_A);
        send_frame(0, TAIL_GOOD, 65535);

        // Widest limit and a frame that fills it: offsets run to 1022.
        set_max_len(10'd1023);
        send_frame(1003, TAIL_GOOD, 65535);

        // Leave a frame open at offset 46; dropping the limit to 20 below
        // makes the next byte an overflow.
        send_frame(100, TAIL_RANDOM, 46);

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:       next_max = 20;
                1:       next_max = 1023;
                3:       next_max = 45;
                5:       next_max = MAX_LEN_RESET;
                default: next_max = $urandom_range(21, 1022);
            endcase
            set_max_len(next_max);
            quiet = (p == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_chunk();
            // about half the phases end with a frame that is often cut short, so the next limit may hit it mid-way
            if ($urandom_range(0, 1))
                send_frame($urandom_range(0, 40), TAIL_RANDOM, $urandom_range(3, 60));
        end
        quiet = 1'b0;

        drain();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
